>>> rtl/core/iira_pkg.sv
package iira_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the request and result
    localparam int ACT_W  = 3;
    localparam int POS_W  = 4;
    localparam int DIN_W  = 32;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;
    localparam int DOUT_W = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int IN_BITS  = ACT_W + POS_W + DIN_W;
    localparam int OUT_BITS = ST_W + OCC_W + DOUT_W;
    localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_DROP    = 3'd1,
        ACT_INS_AT  = 3'd2,
        ACT_REM_AT  = 3'd3,
        ACT_INS_MID = 3'd4,
        ACT_REM_MID = 3'd5,
        ACT_READ    = 3'd6,
        ACT_NOP     = 3'd7
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Edit decided for one request, before qualification by the handshake
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             rd;
        logic [IDX_W-1:0] at;
    } edit_t;

    // Per-cell next-value select
    typedef struct packed {
        logic load;
        logic from_prev;
        logic from_next;
    } cell_cmd_t;

endpackage

>>> rtl/core/iira_cell.sv
module iira_cell (
    input  logic                            aclk,
    input  iira_pkg::cell_cmd_t             cmd,
    input  logic [iira_pkg::DATA_WIDTH-1:0] load_data,
    input  logic [iira_pkg::DATA_WIDTH-1:0] prev_data,
    input  logic [iira_pkg::DATA_WIDTH-1:0] next_data,
    output logic [iira_pkg::DATA_WIDTH-1:0] entry
);

    logic [iira_pkg::DATA_WIDTH-1:0] entry_reg;
    logic [iira_pkg::DATA_WIDTH-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.load) begin
            entry_next = load_data;
        end else if (cmd.from_prev) begin
            entry_next = prev_data;
        end else if (cmd.from_next) begin
            entry_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/core/iira_ctrl.sv
module iira_ctrl (
    input  iira_pkg::action_t              action,
    input  logic [iira_pkg::POS_W-1:0]     position,
    input  logic [iira_pkg::CNT_W-1:0]     count,
    output iira_pkg::status_t              status,
    output logic [iira_pkg::CNT_W-1:0]     count_next,
    output iira_pkg::edit_t                edit
);

    logic                       full;
    logic                       empty;
    logic [iira_pkg::CNT_W-1:0] pos_ext;
    logic [iira_pkg::CNT_W-1:0] count_inc;
    logic [iira_pkg::CNT_W-1:0] count_dec;
    logic [iira_pkg::IDX_W-1:0] mid;

    assign full      = (count == iira_pkg::CNT_W'(iira_pkg::CAPACITY));
    assign empty     = (count == '0);
    assign pos_ext   = iira_pkg::CNT_W'(position);
    assign count_inc = count + iira_pkg::CNT_W'(1);
    assign count_dec = count - iira_pkg::CNT_W'(1);
    assign mid       = iira_pkg::IDX_W'(count >> 1);

    always_comb begin
        status     = iira_pkg::ST_OK;
        count_next = count;
        edit       = '0;
        case (action)
            iira_pkg::ACT_APPEND: begin
                if (full) begin
                    status = iira_pkg::ST_FULL;
                end else begin
                    edit.ins   = 1'b1;
                    edit.at    = iira_pkg::IDX_W'(count);
                    count_next = count_inc;
                end
            end
            iira_pkg::ACT_DROP: begin
                if (empty) begin
                    status = iira_pkg::ST_EMPTY;
                end else begin
                    count_next = count_dec;
                end
            end
            iira_pkg::ACT_INS_AT: begin
                if (full) begin
                    status = iira_pkg::ST_FULL;
                end else if (pos_ext > count) begin
                    status = iira_pkg::ST_RANGE;
                end else begin
                    edit.ins   = 1'b1;
                    edit.at    = iira_pkg::IDX_W'(position);
                    count_next = count_inc;
                end
            end
            iira_pkg::ACT_REM_AT: begin
                if (empty) begin
                    status = iira_pkg::ST_EMPTY;
                end else if (pos_ext >= count) begin
                    status = iira_pkg::ST_RANGE;
                end else begin
                    edit.rem   = 1'b1;
                    edit.at    = iira_pkg::IDX_W'(position);
                    count_next = count_dec;
                end
            end
            iira_pkg::ACT_INS_MID: begin
                if (full) begin
                    status = iira_pkg::ST_FULL;
                end else begin
                    edit.ins   = 1'b1;
                    edit.at    = mid;
                    count_next = count_inc;
                end
            end
            iira_pkg::ACT_REM_MID: begin
                if (empty) begin
                    status = iira_pkg::ST_EMPTY;
                end else begin
                    edit.rem   = 1'b1;
                    edit.at    = mid;
                    count_next = count_dec;
                end
            end
            iira_pkg::ACT_READ: begin
                if (empty) begin
                    status = iira_pkg::ST_EMPTY;
                end else if (pos_ext >= count) begin
                    status = iira_pkg::ST_RANGE;
                end else begin
                    edit.rd = 1'b1;
                    edit.at = iira_pkg::IDX_W'(position);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/indexed_insert_remove_array.sv
// Ordered array of 16 entries of 32 bits with an occupancy count. Each request
// appends, drops the last entry, inserts or removes at an index or at the
// middle (count/2), or reads at an index, and yields one result with status,
// new count and read value (zero unless a read succeeds). A request is taken
// every cycle that the input is ready: the entries sit in a row of cells that
// all shift up or down in the same cycle, and the result of a request shows
// up in the output register in the cycle after acceptance. The input stays
// ready while that register is empty or being drained. Rejected requests (full,
// empty, index out of range) leave the array untouched.
module indexed_insert_remove_array (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action [2:0], position [6:3], data_in [38:7], zero [39]
    input  logic [iira_pkg::IN_TW-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], occupancy [6:2], data_out [38:7], zero [39]
    output logic [iira_pkg::OUT_TW-1:0]   m_tdata
);

    localparam int POS_LO = iira_pkg::ACT_W;
    localparam int DIN_LO = iira_pkg::ACT_W + iira_pkg::POS_W;

    logic                            fire;
    iira_pkg::action_t               req_action;
    logic [iira_pkg::POS_W-1:0]      req_position;
    logic [iira_pkg::DATA_WIDTH-1:0] req_data;

    logic [iira_pkg::CNT_W-1:0]      count_reg;
    logic [iira_pkg::CNT_W-1:0]      count_next;
    iira_pkg::status_t               status;
    iira_pkg::edit_t                 edit;

    logic [iira_pkg::DATA_WIDTH-1:0] entries [iira_pkg::CAPACITY];
    iira_pkg::cell_cmd_t             cmds    [iira_pkg::CAPACITY];
    logic [iira_pkg::DATA_WIDTH-1:0] rd_data;

    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [iira_pkg::OUT_TW-1:0]     m_tdata_reg;
    logic [iira_pkg::OUT_TW-1:0]     m_tdata_next;

    assign s_tready     = !m_tvalid_reg || m_tready;
    assign fire         = s_tvalid && s_tready;
    assign req_action   = iira_pkg::action_t'(s_tdata[iira_pkg::ACT_W-1:0]);
    assign req_position = s_tdata[DIN_LO-1:POS_LO];
    assign req_data     = iira_pkg::DATA_WIDTH'(s_tdata[DIN_LO +: iira_pkg::DIN_W]);

    iira_ctrl u_ctrl (
        .action     (req_action),
        .position   (req_position),
        .count      (count_reg),
        .status     (status),
        .count_next (count_next),
        .edit       (edit)
    );

    genvar i;
    generate
        for (i = 0; i < iira_pkg::CAPACITY; i++) begin : g_cell
            logic [iira_pkg::DATA_WIDTH-1:0] prev_d;
            logic [iira_pkg::DATA_WIDTH-1:0] next_d;

            // Insert: load at the slot, later cells take their lower neighbor.
            // Remove: the slot and later cells take their upper neighbor.
            assign cmds[i].load      = fire && edit.ins && (edit.at == iira_pkg::IDX_W'(i));
            assign cmds[i].from_prev = fire && edit.ins && (edit.at <  iira_pkg::IDX_W'(i));
            assign cmds[i].from_next = fire && edit.rem && (edit.at <= iira_pkg::IDX_W'(i));

            if (i == 0) begin : g_first
                assign prev_d = '0;
            end else begin : g_mid_prev
                assign prev_d = entries[i-1];
            end

            if (i == iira_pkg::CAPACITY - 1) begin : g_last
                assign next_d = entries[i];
            end else begin : g_mid_next
                assign next_d = entries[i+1];
            end

            iira_cell u_cell (
                .aclk      (aclk),
                .cmd       (cmds[i]),
                .load_data (req_data),
                .prev_data (prev_d),
                .next_data (next_d),
                .entry     (entries[i])
            );
        end
    endgenerate

    assign rd_data = edit.rd ? entries[edit.at] : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = iira_pkg::OUT_TW'({iira_pkg::DOUT_W'(rd_data),
                                               iira_pkg::OCC_W'(count_next),
                                               status});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
